// ----- hdl/rmsn_pkg.sv -----
package rmsn_pkg;

    localparam int DATA_W  = 16;
    localparam int CFG_W   = 13;
    localparam int SUM_W   = 44;
    localparam int SQ_W    = 31;
    localparam int SCALE_W = 24;
    localparam int DIVD_W  = 57;
    localparam int DIVS_W  = 45;
    localparam int SQRT_W  = 49;
    localparam int ROOT_W  = 50;
    localparam int ITER_W  = 6;
    localparam int PROD1_W = 41;
    localparam int PROD2_W = 57;
    localparam int FRAC_SHIFT = 28;

    localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [DIVS_W-1:0]  EPS_Q824   = DIVS_W'(168);
    localparam logic [SCALE_W-1:0] SCALE_ONE  = 24'h010000;
    localparam logic [SCALE_W-1:0] SCALE_MAX  = {SCALE_W{1'b1}};
    localparam logic [DIVD_W-1:0]  DIVD_ONE   = {1'b1, {(DIVD_W-1){1'b0}}};
    localparam logic [ROOT_W-1:0]  SQRT_BIT0  = ROOT_W'(1) << (SQRT_W - 1);
    localparam logic [ITER_W-1:0]  ITER_LAST  = ITER_W'(DIVD_W - 1);
    localparam logic [PROD2_W-1:0] ROUND_HALF = PROD2_W'(1) << (FRAC_SHIFT - 1);

    typedef enum logic
    {
        REQ_SQUARE,
        REQ_SCALE
    } req_kind_t;

    typedef struct packed
    {
        req_kind_t           kind;
        logic [DATA_W-1:0]   activation;
        logic [DATA_W-1:0]   weight;
        logic [SQ_W-1:0]     square;
    } rmsn_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } rmsn_root_sts_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_ROUND,
        BK_ROOT
    } back_state_t;

    typedef enum logic [2:0]
    {
        RT_IDLE,
        RT_MEAN,
        RT_EPS,
        RT_RECIP,
        RT_SQRT,
        RT_DONE
    } root_state_t;

endpackage

// ----- hdl/rmsn_fifo.sv -----
module rmsn_fifo
    import rmsn_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (ADDR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/rmsn_front.sv -----
module rmsn_front
    import rmsn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              command,
    input  logic [DATA_W-1:0] activation,
    input  logic [DATA_W-1:0] weight,
    output logic              req_push,
    output rmsn_req_t         req,
    input  logic              req_full
);

    logic                valid_reg, valid_next;
    rmsn_req_t           req_reg, req_next;
    logic                load;
    logic signed [31:0]  square_full;

    assign full        = valid_reg && req_full;
    assign load        = push && !full;
    assign req_push    = valid_reg;
    assign req         = req_reg;
    assign square_full = $signed(activation) * $signed(activation);

    always_comb
    begin
        valid_next = load || (valid_reg && req_full);
        req_next   = req_reg;
        if (load)
        begin
            req_next.kind       = command ? REQ_SCALE : REQ_SQUARE;
            req_next.activation = activation;
            req_next.weight     = weight;
            req_next.square     = square_full[SQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

// ----- hdl/rmsn_root.sv -----
module rmsn_root
    import rmsn_pkg::*;
#(
    parameter int MAX_LEN = 4096
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [SUM_W-1:0]                     sum,
    input  logic [$clog2(MAX_LEN + 1)-1:0]       len,
    output rmsn_root_sts_t                       sts,
    output logic [SCALE_W-1:0]                   scale
);

    root_state_t         state_reg, state_next;
    logic [DIVD_W-1:0]   work_reg, work_next;
    logic [DIVS_W-1:0]   div_reg, div_next;
    logic [DIVS_W:0]     rem_reg, rem_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W-1:0]   bit_reg, bit_next;

    logic [DIVS_W:0]     shifted;
    logic [DIVS_W:0]     diff;
    logic                ge;
    logic [ROOT_W-1:0]   sq_n;
    logic [ROOT_W-1:0]   sq_t;
    logic [ROOT_W-1:0]   sq_rest;
    logic                last_iter;

    assign shifted   = {rem_reg[DIVS_W-1:0], work_reg[DIVD_W-1]};
    assign diff      = shifted - {1'b0, div_reg};
    assign ge        = (shifted >= {1'b0, div_reg});
    assign sq_n      = ROOT_W'(work_reg[SQRT_W-1:0]);
    assign sq_t      = root_reg + bit_reg;
    assign sq_rest   = sq_n - sq_t;
    assign last_iter = (iter_reg == ITER_LAST);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RT_IDLE:
            begin
                if (start)
                begin
                    state_next = RT_MEAN;
                end
            end
            RT_MEAN:
            begin
                if (last_iter)
                begin
                    state_next = RT_EPS;
                end
            end
            RT_EPS:
            begin
                state_next = RT_RECIP;
            end
            RT_RECIP:
            begin
                if (last_iter)
                begin
                    state_next = RT_SQRT;
                end
            end
            RT_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = RT_DONE;
                end
            end
            RT_DONE:
            begin
                state_next = RT_IDLE;
            end
            default:
            begin
                state_next = RT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sts.busy = (state_reg != RT_IDLE);
        sts.done = (state_reg == RT_DONE);
        scale    = (|root_reg[ROOT_W-1:SCALE_W]) ? SCALE_MAX : root_reg[SCALE_W-1:0];
    end

    always_comb
    begin
        work_next = work_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        case (state_reg)
            RT_IDLE:
            begin
                if (start)
                begin
                    work_next = DIVD_W'(sum);
                    div_next  = DIVS_W'(len);
                    rem_next  = '0;
                    iter_next = '0;
                end
            end
            RT_MEAN, RT_RECIP:
            begin
                rem_next  = ge ? diff : shifted;
                work_next = {work_reg[DIVD_W-2:0], ge};
                iter_next = iter_reg + 1'b1;
                if (last_iter)
                begin
                    root_next = '0;
                    bit_next  = SQRT_BIT0;
                end
            end
            RT_EPS:
            begin
                div_next  = DIVS_W'(work_reg[SUM_W-1:0]) + EPS_Q824;
                work_next = DIVD_ONE;
                rem_next  = '0;
                iter_next = '0;
            end
            RT_SQRT:
            begin
                if (sq_n >= sq_t)
                begin
                    work_next = DIVD_W'(sq_rest[SQRT_W-1:0]);
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            default:
            begin
                work_next = work_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RT_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

endmodule

// ----- hdl/rmsn_back.sv -----
module rmsn_back
    import rmsn_pkg::*;
#(
    parameter int MAX_LEN = 4096
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [CFG_W-1:0]                     vector_length,
    input  rmsn_req_t                            req,
    input  logic                                 req_empty,
    output logic                                 req_pop,
    output logic                                 root_start,
    output logic [SUM_W-1:0]                     root_sum,
    output logic [$clog2(MAX_LEN + 1)-1:0]       root_len,
    input  rmsn_root_sts_t                       root_sts,
    input  logic [SCALE_W-1:0]                   root_scale,
    output logic                                 out_push,
    output logic [DATA_W-1:0]                    out_data,
    input  logic                                 out_full
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_LEN);
    localparam int Y_W = PROD2_W - FRAC_SHIFT;

    back_state_t               state_reg, state_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SCALE_W-1:0]        inv_rms_reg, inv_rms_next;
    logic [DATA_W-1:0]         act_reg, act_next;
    logic [DATA_W-1:0]         wgt_reg, wgt_next;
    logic signed [PROD1_W-1:0] prod1_reg, prod1_next;
    logic signed [PROD2_W-1:0] prod2_reg, prod2_next;

    logic [SUM_W:0]            sum_ext;
    logic [SUM_W-1:0]          sum_sat;
    logic [CNT_W-1:0]          cnt_inc;
    logic [CMP_W-1:0]          vl_cmp;
    logic [CMP_W-1:0]          eff_cmp;
    logic [CNT_W-1:0]          eff_len;
    logic                      vec_end;
    logic signed [PROD1_W-1:0] act_ext;
    logic signed [PROD1_W-1:0] scale_ext;
    logic signed [PROD2_W-1:0] prod1_ext;
    logic signed [PROD2_W-1:0] wgt_ext;
    logic [PROD2_W-1:0]        rounded;
    logic [Y_W-1:0]            y;
    logic                      ovf_pos;
    logic                      ovf_neg;

    assign sum_ext = {1'b0, sum_reg} + (SUM_W+1)'(req.square);
    assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    assign cnt_inc = count_reg + CNT_W'(1);
    assign vl_cmp  = CMP_W'(vector_length);

    always_comb
    begin
        if (vector_length == '0)
        begin
            eff_cmp = CMP_W'(1);
        end
        else if (vl_cmp > MAX_CMP)
        begin
            eff_cmp = MAX_CMP;
        end
        else
        begin
            eff_cmp = vl_cmp;
        end
    end

    assign eff_len  = eff_cmp[CNT_W-1:0];
    assign vec_end  = (cnt_inc >= eff_len);
    assign root_sum = sum_sat;
    assign root_len = eff_len;

    assign act_ext   = PROD1_W'($signed(act_reg));
    assign scale_ext = $signed(PROD1_W'(inv_rms_reg));
    assign prod1_ext = PROD2_W'(prod1_reg);
    assign wgt_ext   = PROD2_W'($signed(wgt_reg));

    assign rounded = prod2_reg + ROUND_HALF;
    assign y       = rounded[PROD2_W-1:FRAC_SHIFT];
    assign ovf_pos = !y[Y_W-1] && (|y[Y_W-2:DATA_W-1]);
    assign ovf_neg = y[Y_W-1] && !(&y[Y_W-2:DATA_W-1]);

    always_comb
    begin
        if (ovf_pos)
        begin
            out_data = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (ovf_neg)
        begin
            out_data = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            out_data = y[DATA_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!req_empty)
                begin
                    if (req.kind == REQ_SCALE)
                    begin
                        state_next = BK_MUL1;
                    end
                    else if (vec_end)
                    begin
                        state_next = BK_ROOT;
                    end
                end
            end
            BK_MUL1:
            begin
                state_next = BK_MUL2;
            end
            BK_MUL2:
            begin
                state_next = BK_ROUND;
            end
            BK_ROUND:
            begin
                if (!out_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_ROOT:
            begin
                if (root_sts.done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_pop    = (state_reg == BK_IDLE) && !req_empty;
        root_start = req_pop && (req.kind == REQ_SQUARE) && vec_end;
        out_push   = (state_reg == BK_ROUND) && !out_full;
    end

    always_comb
    begin
        sum_next     = sum_reg;
        count_next   = count_reg;
        inv_rms_next = inv_rms_reg;
        act_next     = act_reg;
        wgt_next     = wgt_reg;
        prod1_next   = prod1_reg;
        prod2_next   = prod2_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (req_pop)
                begin
                    if (req.kind == REQ_SCALE)
                    begin
                        act_next = req.activation;
                        wgt_next = req.weight;
                    end
                    else if (vec_end)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        sum_next   = sum_sat;
                        count_next = cnt_inc;
                    end
                end
            end
            BK_MUL1:
            begin
                prod1_next = act_ext * scale_ext;
            end
            BK_MUL2:
            begin
                prod2_next = prod1_ext * wgt_ext;
            end
            BK_ROOT:
            begin
                if (root_sts.done)
                begin
                    inv_rms_next = root_scale;
                end
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            inv_rms_reg <= SCALE_ONE;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            inv_rms_reg <= inv_rms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        wgt_reg   <= wgt_next;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
    end

endmodule

// ----- hdl/rms_normalization.sv -----
// RMS normalization of a vector in two passes over vector_length elements (0 acts as 1,
// values above MAX_LEN act as MAX_LEN). A request with command 0 adds the square of its
// Q4.12 activation to a saturating sum and gives no result; a request with command 1 gives
// one Q4.12 result, activation times scale times weight, rounded to nearest (ties up) and
// saturated. The scale is unsigned Q8.16, 1.0 after reset, and is replaced when a vector's
// last square arrives by floor(2^28 / sqrt(sum / length + 168)). A small request queue
// separates intake from execution, so push keeps being taken while results wait. A square
// request is taken in the execution side's idle state; an output request goes through two
// multiply stages and a round stage that writes it, waiting while the output queue is full.
// A vector's last square starts the shared iterative divide and square-root unit (two
// 57-step divisions, a 25-step square root); queued requests wait; intake runs until full.
module rms_normalization
    import rmsn_pkg::*;
#(
    parameter int MAX_LEN = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              command,
    input  logic [DATA_W-1:0] activation,
    input  logic [DATA_W-1:0] weight,
    output logic              empty,
    input  logic              pop,
    output logic [DATA_W-1:0] normalized,
    input  logic              cfg_write,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int REQ_W = $bits(rmsn_req_t);

    logic [CFG_W-1:0]  vector_length_reg, vector_length_next;

    logic              req_push;
    rmsn_req_t         req_in;
    logic              req_full;
    logic              req_pop;
    rmsn_req_t         req_out;
    logic              req_empty;

    logic              root_start;
    logic [SUM_W-1:0]  root_sum;
    logic [CNT_W-1:0]  root_len;
    rmsn_root_sts_t    root_sts;
    logic [SCALE_W-1:0] root_scale;

    logic              out_push;
    logic [DATA_W-1:0] out_data;
    logic              out_full;

    assign vector_length_next = cfg_write ? cfg_data : vector_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= CFG_W'(1);
        end
        else
        begin
            vector_length_reg <= vector_length_next;
        end
    end

    rmsn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .activation (activation),
        .weight     (weight),
        .req_push   (req_push),
        .req        (req_in),
        .req_full   (req_full)
    );

    rmsn_fifo #(.WIDTH(REQ_W), .DEPTH(4)) u_req_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (req_push),
        .wr_data (req_in),
        .full    (req_full),
        .pop     (req_pop),
        .rd_data (req_out),
        .empty   (req_empty)
    );

    rmsn_back #(.MAX_LEN(MAX_LEN)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .vector_length (vector_length_reg),
        .req           (req_out),
        .req_empty     (req_empty),
        .req_pop       (req_pop),
        .root_start    (root_start),
        .root_sum      (root_sum),
        .root_len      (root_len),
        .root_sts      (root_sts),
        .root_scale    (root_scale),
        .out_push      (out_push),
        .out_data      (out_data),
        .out_full      (out_full)
    );

    rmsn_root #(.MAX_LEN(MAX_LEN)) u_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .sum   (root_sum),
        .len   (root_len),
        .sts   (root_sts),
        .scale (root_scale)
    );

    rmsn_fifo #(.WIDTH(DATA_W), .DEPTH(2)) u_out_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_data),
        .full    (out_full),
        .pop     (pop),
        .rd_data (normalized),
        .empty   (empty)
    );

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) root_start |-> !root_sts.busy)
        else $error("root unit started while busy");
    assert property (@(posedge clk) disable iff (!rst_n) root_sts.busy |-> !req_pop)
        else $error("request taken while scale is being computed");
    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result written into a full output queue");
    assert property (@(posedge clk) disable iff (!rst_n) $fell(empty) |-> $past(out_push))
        else $error("result appeared without a write");
`endif

endmodule

// ----- sim/tb_rms_normalization.sv -----
module tb_rms_normalization;
    import rmsn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN        = 4096;
    localparam int TOTAL_REQUESTS = 475;
    localparam int DRAIN_REQUESTS = 60;
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 5000;

    class rms_scoreboard;
        logic [CFG_W-1:0]   vec_len;
        logic [SUM_W-1:0]   sum_sq;
        logic [CFG_W-1:0]   elem_cnt;
        logic [SCALE_W-1:0] scale;
        logic [DATA_W-1:0]  expected_q[$];
        int                 errors;

        function new();
            vec_len  = CFG_W'(1);
            sum_sq   = '0;
            elem_cnt = '0;
            scale    = SCALE_ONE;
            errors   = 0;
        endfunction

        function void set_length(logic [CFG_W-1:0] v);
            vec_len = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        static function logic [63:0] floor_sqrt(logic [63:0] n);
            logic [63:0] root;
            logic [63:0] cand;
            root = '0;
            for (int b = 27; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                if (cand * cand <= n)
                    root = cand;
            end
            return root;
        endfunction

        function void note_request(req_kind_t kind, logic [DATA_W-1:0] act,
                                   logic [DATA_W-1:0] wgt);
            longint      a_s;
            longint      w_s;
            longint      prod;
            longint      y;
            logic [63:0] sq;
            logic [63:0] len;
            logic [63:0] mean;
            logic [63:0] root;
            a_s = longint'($signed(act));
            if (kind == REQ_SQUARE)
            begin
                if (vec_len == 0)
                    len = 64'd1;
                else if (vec_len > MAX_LEN)
                    len = 64'(MAX_LEN);
                else
                    len = 64'(vec_len);
                sq = 64'(a_s * a_s);
                if (sq > 64'(SUM_MAX) - 64'(sum_sq))
                    sum_sq = SUM_MAX;
                else
                    sum_sq = sum_sq + SUM_W'(sq);
                elem_cnt = elem_cnt + 1'b1;
                if (64'(elem_cnt) >= len)
                begin
                    mean  = 64'(sum_sq) / len + 64'(EPS_Q824);
                    root  = floor_sqrt((64'd1 << 56) / mean);
                    scale = (root > 64'(SCALE_MAX)) ? SCALE_MAX : SCALE_W'(root);
                    sum_sq   = '0;
                    elem_cnt = '0;
                end
            end
            else
            begin
                w_s  = longint'($signed(wgt));
                prod = a_s * longint'(scale) * w_s;
                y    = (prod + (longint'(1) << 27)) >>> 28;
                if (y > 32767)
                    y = 32767;
                else if (y < -32768)
                    y = -32768;
                expected_q.push_back(DATA_W'(y));
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] exp_val;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no request waiting, expected none, actual %0d",
                         $time, $signed(got));
                errors++;
            end
            else
            begin
                exp_val = expected_q.pop_front();
                if (got !== exp_val)
                begin
                    $display("%0t: normalized mismatch, expected %0d, actual %0d",
                             $time, $signed(exp_val), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              command;
    logic [DATA_W-1:0] activation;
    logic [DATA_W-1:0] weight;
    logic              empty;
    logic              pop;
    logic [DATA_W-1:0] normalized;
    logic              cfg_write;
    logic [CFG_W-1:0]  cfg_data;

    rms_scoreboard sb = new();

    int requests_sent = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int stall_cycles  = 0;
    bit drain_mode    = 1'b0;
    bit hold_req      = 1'b0;

    rms_normalization u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .activation (activation),
        .weight     (weight),
        .empty      (empty),
        .pop        (pop),
        .normalized (normalized),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result(normalized);
            if (push && !full)
                sb.note_request(req_kind_t'(command), activation, weight);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (!push && sb.pending() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                pop <= 1'b1;
            end
            else if (!drain_mode && $urandom_range(0, 99) < rx_idle_pct)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                pop <= 1'b1;
            end
            else
                pop <= 1'b1;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value(int cls);
        logic [DATA_W-1:0] v;
        case (cls)
            1:       v = DATA_W'($urandom_range(0, 8191)) - DATA_W'(4096);
            2:       v = DATA_W'($urandom_range(0, 127)) - DATA_W'(64);
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default: v = DATA_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_request(req_kind_t kind, logic [DATA_W-1:0] act,
                                logic [DATA_W-1:0] wgt);
        if (!drain_mode && $urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        push       <= 1'b1;
        command    <= kind;
        activation <= act;
        weight     <= wgt;
        @(posedge clk);
        while (full)
            @(posedge clk);
        requests_sent++;
        if (requests_sent >= TOTAL_REQUESTS - DRAIN_REQUESTS)
            drain_mode = 1'b1;
    endtask

    // hold off until every result is back and the scale update has settled
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_vector_length(logic [CFG_W-1:0] v);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_length(v);
    endtask

    initial
    begin
        int                phase;
        int                roll;
        int                len;
        int                eff;
        int                acls;
        int                nsq;
        int                n;
        logic [DATA_W-1:0] acts[$];

        rst_n      = 1'b0;
        push       = 1'b0;
        command    = 1'b0;
        activation = '0;
        weight     = '0;
        cfg_write  = 1'b0;
        cfg_data   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scale is still 1.0: saturation, rounding ties, plain products
        send_request(REQ_SCALE, 16'h7FFF, 16'h7FFF);
        send_request(REQ_SCALE, 16'h8000, 16'h8000);
        send_request(REQ_SCALE, 16'h8000, 16'h7FFF);
        send_request(REQ_SCALE, 16'h0001, 16'h0800);
        send_request(REQ_SCALE, 16'hFFFF, 16'h0800);
        send_request(REQ_SCALE, 16'h1000, 16'h1000);
        // all-zero vector drives the scale to its ceiling
        send_request(REQ_SQUARE, 16'h0000, DATA_W'($urandom));
        send_request(REQ_SCALE, 16'h0001, 16'h0001);
        send_request(REQ_SCALE, 16'h7FFF, 16'h8000);

        set_vector_length(CFG_W'(0));
        send_request(REQ_SQUARE, 16'h8000, DATA_W'($urandom));
        send_request(REQ_SCALE, 16'h7FFF, 16'h7FFF);
        send_request(REQ_SCALE, 16'h8000, 16'hFFFF);

        // shrink the length with a vector half done
        set_vector_length(CFG_W'(3));
        send_request(REQ_SQUARE, 16'h7FFF, DATA_W'($urandom));
        send_request(REQ_SQUARE, 16'h8000, DATA_W'($urandom));
        set_vector_length(CFG_W'(2));
        send_request(REQ_SQUARE, 16'h1234, DATA_W'($urandom));
        send_request(REQ_SCALE, DATA_W'($urandom), DATA_W'($urandom));

        set_vector_length({CFG_W{1'b1}});
        repeat (3) send_request(REQ_SQUARE, DATA_W'($urandom), DATA_W'($urandom));
        send_request(REQ_SCALE, DATA_W'($urandom), DATA_W'($urandom));
        set_vector_length(CFG_W'(MAX_LEN));
        send_request(REQ_SQUARE, DATA_W'($urandom), DATA_W'($urandom));
        send_request(REQ_SCALE, DATA_W'($urandom), DATA_W'($urandom));

        phase = 0;
        while (requests_sent < TOTAL_REQUESTS)
        begin
            phase++;
            tx_idle_pct = 10 * $urandom_range(0, 3);
            rx_idle_pct = 10 * $urandom_range(0, 3);
            roll        = $urandom_range(0, 99);
            if (phase == 4)
            begin
                // receiver holds off while requests keep coming until full
                set_vector_length(CFG_W'($urandom_range(1, 8)));
                tx_idle_pct = 0;
                hold_req    = 1'b1;
                repeat (48) send_request(REQ_SCALE, pick_value(0), pick_value(0));
            end
            else if (roll < 75)
            begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                eff = (len == 0) ? 1 : len;
                set_vector_length(CFG_W'(len));
                acls = $urandom_range(0, 3);
                nsq  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff) : eff;
                acts.delete();
                for (int i = 0; i < eff; i++)
                    acts.push_back(pick_value(acls));
                for (int i = 0; i < nsq; i++)
                    send_request(REQ_SQUARE, acts[i], DATA_W'($urandom));
                for (int i = 0; i < eff; i++)
                    send_request(REQ_SCALE, acts[i], pick_value($urandom_range(0, 3)));
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       len = 0;
                    1:       len = MAX_LEN;
                    2:       len = (1 << CFG_W) - 1;
                    3:       len = $urandom_range(MAX_LEN + 1, (1 << CFG_W) - 2);
                    default: len = $urandom_range(1, 10);
                endcase
                set_vector_length(CFG_W'(len));
                n = $urandom_range(4, 20);
                repeat (n)
                    send_request(req_kind_t'($urandom_range(0, 1)),
                                 pick_value($urandom_range(0, 3)), pick_value(0));
            end
        end

        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
